FILE: rtl/ccdf_pkg.sv
// Shared types, constants and the CRC-16/CCITT-FALSE byte step for the
// COBS datagram deframer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccdf_pkg;

  // Framing constants
  localparam logic [7:0]  DELIM        = 8'h00;
  localparam logic [7:0]  CODE_FULL    = 8'hFF;
  localparam int unsigned MIN_FRAME    = 5;
  localparam logic [7:0]  NUM_CHANNELS = 8'd3;
  localparam logic [1:0]  CHAN_NONE    = 2'd3;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Result item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Frame status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_CRC_FAIL = 2'd1;
  localparam logic [1:0] STAT_DEC_FAIL = 2'd2;

  // Output beat packing (tdata, lowest bit first)
  localparam int unsigned OUT_DATA_W = 152;

  // Control from the deframer to the CRC unit
  typedef struct packed {
    logic       clear;
    logic       feed;
    logic [7:0] data;
  } crc_ctl_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ccdf_crc16.sv
// Running CRC-16/CCITT-FALSE register, one byte per cycle.
// Depends on ccdf_pkg for the control struct and the byte step.
`timescale 1ns / 1ps
`default_nettype none

module ccdf_crc16 (
  input  wire logic                clk,
  input  wire ccdf_pkg::crc_ctl_t  ctl,
  output logic [15:0]              crc
);
  import ccdf_pkg::*;

  // Clear to the initial value, or fold in one byte.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      crc <= CRC_INIT;
    end else if (ctl.feed) begin
      crc <= crc16_byte(crc, ctl.data);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cobs_crc_datagram_deframer_core.sv
// Receive-side COBS deframer with CRC-16/CCITT-FALSE check and counters.
// Depends on ccdf_pkg and ccdf_crc16.
`timescale 1ns / 1ps
`default_nettype none

// A nonzero received byte is written into the frame store while it has
// room, and the block stays ready for the next byte. A zero byte that ends
// a nonempty frame starts the decode: the frame store has one read port
// with a registered read, so each stored byte is first read (S_DEC_RD) and
// then decoded (S_DEC_PROC), and each zero restored between COBS blocks
// needs no state of its own, since it is written during the next read.
// Decoded bytes go into a second memory while the CRC runs alongside. The
// S_FINISH state then checks the header, length and CRC and updates the
// counters. A good frame on an enabled channel is replayed from the decoded
// memory, each payload byte being read (S_RP_RD) and then loaded into the
// output register (S_RP_OUT); then the status beat follows. The input is
// not ready from the delimiter until the status beat has been loaded into
// the output register. Output beats wait in that register until taken, and
// a full register stalls the replay. A decode error ends the decode early.
// Both memories start undefined; only entries written since the last
// delimiter are ever read, so no clearing pass runs.
module cobs_crc_datagram_deframer_core #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration: channel_enable_mask
  input  wire logic                              cfg_wr_en,
  input  wire logic [2:0]                        cfg_wr_data,
  // Received bytes
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,   // [7:0] rx_byte
  // Result beats
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [1:0] channel, [9:2] data_byte, [11:10] frame_status,
  // [17:12] payload_length, [49:18] ok_count, [81:50] crc_fail_count,
  // [113:82] decode_fail_count, [145:114] oversize_count, [151:146] zero
  output logic [ccdf_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic [0:0]                             m_tuser,   // [0] item_kind
  output logic                                   m_tlast    // last
);
  import ccdf_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] BUF_LIMIT = CW'(BUFFER_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC_RD,
    S_DEC_PROC,
    S_FINISH,
    S_RP_RD,
    S_RP_OUT,
    S_STATUS
  } state_t;

  state_t state;

  // Frame assembly and decode registers
  logic [CW-1:0] fill;
  logic [CW-1:0] nbytes;
  logic [CW-1:0] rd_idx;
  logic [7:0]    run_left;
  logic          code_ff;
  logic          zero_pend;
  logic          err;
  logic [CW-1:0] dec_cnt;
  logic [7:0]    d_last;
  logic [7:0]    d_prev;
  logic [7:0]    chan_r;
  logic [15:0]   len_r;
  logic [CW-1:0] rp_idx;
  logic [2:0]    enable_mask;

  // Counters
  logic [31:0] ok_count;
  logic [31:0] crc_fail_count;
  logic [31:0] decode_fail_count;
  logic [31:0] oversize_count;

  // Per-frame result
  logic [1:0] res_status;
  logic [1:0] res_chan;
  logic [5:0] res_plen;

  // Output register fields
  logic        o_kind;
  logic [1:0]  o_chan;
  logic [7:0]  o_data;
  logic [1:0]  o_status;
  logic [5:0]  o_plen;
  logic        o_last;
  logic [31:0] o_ok;
  logic [31:0] o_crc_fail;
  logic [31:0] o_dec_fail;
  logic [31:0] o_oversize;

  // Memories
  logic [7:0] frame_store [BUFFER_BYTES];
  logic [7:0] dec_store   [BUFFER_BYTES];
  logic [7:0] store_q;
  logic [7:0] dec_q;

  logic          in_beat;
  logic          store_we;
  logic          out_free;
  logic          out_load;
  logic [CW-1:0] rem_after;
  logic [7:0]    code_run;
  logic          run_bad;
  logic          emit_req;
  logic          emit_we;
  logic          emit_ovf;
  logic [7:0]    emit_byte;
  logic [CW-1:0] rp_sum;
  logic [AW-1:0] rp_addr;
  logic [16:0]   len_plus;
  logic          dec_fail;
  logic          crc_bad;
  logic [3:0]    mask4;
  logic          deliver;
  logic [15:0]   crc_val;
  crc_ctl_t      crc_ctl;

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign store_we = in_beat && (s_tdata != DELIM) && (fill < BUF_LIMIT);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = ((state == S_RP_OUT) || (state == S_STATUS)) && out_free;

  // Frame store: written on arrival, read during decode.
  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_store[fill[AW-1:0]] <= s_tdata;
    end
    if (state == S_DEC_RD) begin
      store_q <= frame_store[rd_idx[AW-1:0]];
    end
  end

  // Decoded store: written while decoding, read during payload replay.
  assign rp_sum  = rp_idx + CW'(3);
  assign rp_addr = rp_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (emit_we) begin
      dec_store[dec_cnt[AW-1:0]] <= emit_byte;
    end
    if (state == S_RP_RD) begin
      dec_q <= dec_store[rp_addr];
    end
  end

  // COBS step on the byte just read.
  assign rem_after = nbytes - rd_idx - CW'(1);
  assign code_run  = store_q - 8'd1;
  assign run_bad   = code_run > 8'(rem_after);

  always_comb begin
    emit_req  = 1'b0;
    emit_byte = store_q;
    case (state)
      S_DEC_RD: begin
        emit_req  = zero_pend;
        emit_byte = 8'h00;
      end
      S_DEC_PROC: begin
        emit_req = (run_left != 8'd0);
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign emit_we  = emit_req && (dec_cnt < BUF_LIMIT);
  assign emit_ovf = emit_req && !(dec_cnt < BUF_LIMIT);

  // The CRC trails the decoded stream by two bytes, which leaves the
  // trailing CRC field out of the sum.
  assign crc_ctl.clear = (state == S_IDLE);
  assign crc_ctl.feed  = emit_we && (dec_cnt >= CW'(2));
  assign crc_ctl.data  = d_prev;

  ccdf_crc16 u_crc (
    .clk (clk),
    .ctl (crc_ctl),
    .crc (crc_val)
  );

  // Frame checks once the decode has finished.
  assign len_plus = {1'b0, len_r} + 17'(MIN_FRAME);
  assign dec_fail = err || (dec_cnt < CW'(MIN_FRAME)) || (chan_r >= NUM_CHANNELS) ||
                    (17'(dec_cnt) != len_plus);
  assign crc_bad  = crc_val != {d_last, d_prev};
  assign mask4    = {1'b0, enable_mask};
  assign deliver  = mask4[chan_r[1:0]] && (len_r != 16'd0);

  // Sequencer, counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      fill              <= '0;
      zero_pend         <= 1'b0;
      err               <= 1'b0;
      enable_mask       <= 3'd0;
      ok_count          <= 32'd0;
      crc_fail_count    <= 32'd0;
      decode_fail_count <= 32'd0;
      oversize_count    <= 32'd0;
      m_tvalid          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enable_mask <= cfg_wr_data;
      end

      // The output register fills on a load and empties when its beat is taken.
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Decoded byte bookkeeping
      if (emit_we) begin
        dec_cnt <= dec_cnt + CW'(1);
        d_prev  <= d_last;
        d_last  <= emit_byte;
        if (dec_cnt == CW'(0)) begin
          chan_r <= emit_byte;
        end
        if (dec_cnt == CW'(1)) begin
          len_r[7:0] <= emit_byte;
        end
        if (dec_cnt == CW'(2)) begin
          len_r[15:8] <= emit_byte;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            if (s_tdata != DELIM) begin
              if (fill < BUF_LIMIT) begin
                fill <= fill + CW'(1);
              end else begin
                oversize_count <= oversize_count + 32'd1;
              end
            end else if (fill != '0) begin
              nbytes    <= fill;
              fill      <= '0;
              rd_idx    <= '0;
              run_left  <= 8'd0;
              zero_pend <= 1'b0;
              err       <= 1'b0;
              dec_cnt   <= '0;
              state     <= S_DEC_RD;
            end
          end
        end
        S_DEC_RD: begin
          zero_pend <= 1'b0;
          if (emit_ovf) begin
            err   <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_DEC_PROC;
          end
        end
        S_DEC_PROC: begin
          rd_idx <= rd_idx + CW'(1);
          if (run_left == 8'd0) begin
            // Code byte opens a block
            if ((store_q == DELIM) || run_bad) begin
              err   <= 1'b1;
              state <= S_FINISH;
            end else begin
              run_left <= code_run;
              code_ff  <= (store_q == CODE_FULL);
              if ((code_run == 8'd0) && (store_q != CODE_FULL) && (rem_after != '0)) begin
                zero_pend <= 1'b1;
              end
              state <= (rem_after != '0) ? S_DEC_RD : S_FINISH;
            end
          end else if (emit_ovf) begin
            err   <= 1'b1;
            state <= S_FINISH;
          end else begin
            // Data byte inside a block
            run_left <= run_left - 8'd1;
            if ((run_left == 8'd1) && !code_ff && (rem_after != '0)) begin
              zero_pend <= 1'b1;
            end
            state <= (rem_after != '0) ? S_DEC_RD : S_FINISH;
          end
        end
        S_FINISH: begin
          if (dec_fail) begin
            decode_fail_count <= decode_fail_count + 32'd1;
            res_status        <= STAT_DEC_FAIL;
            res_chan          <= CHAN_NONE;
            res_plen          <= 6'd0;
            state             <= S_STATUS;
          end else if (crc_bad) begin
            crc_fail_count <= crc_fail_count + 32'd1;
            res_status     <= STAT_CRC_FAIL;
            res_chan       <= CHAN_NONE;
            res_plen       <= 6'd0;
            state          <= S_STATUS;
          end else begin
            ok_count   <= ok_count + 32'd1;
            res_status <= STAT_OK;
            res_chan   <= chan_r[1:0];
            res_plen   <= len_r[5:0];
            rp_idx     <= '0;
            state      <= deliver ? S_RP_RD : S_STATUS;
          end
        end
        S_RP_RD: begin
          state <= S_RP_OUT;
        end
        S_RP_OUT: begin
          if (out_free) begin
            o_kind     <= KIND_PAYLOAD;
            o_chan     <= res_chan;
            o_data     <= dec_q;
            o_status   <= STAT_OK;
            o_plen     <= res_plen;
            o_last     <= 1'b0;
            o_ok       <= ok_count;
            o_crc_fail <= crc_fail_count;
            o_dec_fail <= decode_fail_count;
            o_oversize <= oversize_count;
            rp_idx     <= rp_idx + CW'(1);
            state      <= ((16'(rp_idx) + 16'd1) == len_r) ? S_STATUS : S_RP_RD;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            o_kind     <= KIND_STATUS;
            o_chan     <= res_chan;
            o_data     <= 8'h00;
            o_status   <= res_status;
            o_plen     <= res_plen;
            o_last     <= 1'b1;
            o_ok       <= ok_count;
            o_crc_fail <= crc_fail_count;
            o_dec_fail <= decode_fail_count;
            o_oversize <= oversize_count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output beat packing
  assign m_tdata = {6'd0, o_oversize, o_dec_fail, o_crc_fail, o_ok,
                    o_plen, o_status, o_data, o_chan};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

  // The fill level is cleared when a frame is taken for decode and stays
  // clear until the input is accepted again.
  a_fill_clear_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (fill == '0))
    else $error("fill level nonzero while a frame is in work");

  // The decoded byte count never exceeds the buffer.
  a_dec_cnt_bounded: assert property (@(posedge clk) disable iff (rst)
    (dec_cnt <= BUF_LIMIT) || (state == S_IDLE))
    else $error("decoded byte count past buffer");

  // A payload beat always reports a good frame and never ends the run.
  a_payload_beat_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_PAYLOAD)) |->
      ((m_tdata[11:10] == STAT_OK) && !m_tlast && (m_tdata[1:0] != CHAN_NONE)))
    else $error("payload beat with bad status");

  // Frame counters move only in the check cycle.
  a_counters_only_at_check: assert property (@(posedge clk) disable iff (rst)
    (state != S_FINISH) |=>
      ((ok_count == $past(ok_count)) && (crc_fail_count == $past(crc_fail_count)) &&
       (decode_fail_count == $past(decode_fail_count))))
    else $error("frame counter changed outside the check cycle");

endmodule

`default_nettype wire

FILE: bench/cobs_crc_datagram_deframer_core_tb.sv
// Self-checking bench for the COBS/CRC-16 datagram deframer core.
// Depends on ccdf_pkg and the deframer RTL; predicts every result beat from the byte stream.
`timescale 1ns / 1ps

module cobs_crc_datagram_deframer_core_tb;
  import ccdf_pkg::*;

  localparam int FRAME_BYTES     = 64;
  localparam int STALL_LIMIT     = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int TAIL_CYCLES     = 64;

  // One result beat, split into its fields.
  typedef struct packed {
    logic        kind;
    logic [1:0]  chan;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [5:0]  plen;
    logic        last;
    logic [31:0] ok_cnt;
    logic [31:0] crc_cnt;
    logic [31:0] dec_cnt;
    logic [31:0] drop_cnt;
  } beat_t;

  // Kinds of frames the stimulus can build.
  typedef enum {
    FLAW_NONE, FLAW_CRC, FLAW_CHAN, FLAW_LEN, FLAW_SHORT, FLAW_NOISE, FLAW_OVERSIZE
  } frame_flaw_t;

  // Tracks the frame being received, the counters and the result beats still due.
  class deframe_ledger;
    logic [7:0]  stored[$];
    logic [7:0]  decoded[$];
    beat_t       due_beats[$];
    logic [31:0] ok_total = '0;
    logic [31:0] crc_bad_total = '0;
    logic [31:0] decode_bad_total = '0;
    logic [31:0] dropped_total = '0;
    logic [2:0]  enable_mask = '0;
    int          mismatches = 0;

    // CRC-16/CCITT-FALSE, one bit at a time, MSB first.
    static function logic [15:0] crc16_of(input logic [7:0] bytes[$], input int n);
      logic [15:0] crc;
      logic        fb;
      crc = CRC_INIT;
      for (int i = 0; i < n; i++) begin
        for (int b = 7; b >= 0; b--) begin
          fb  = crc[15] ^ bytes[i][b];
          crc = {crc[14:0], 1'b0};
          if (fb) crc = crc ^ CRC_POLY;
        end
      end
      return crc;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Undo the byte stuffing of the stored frame; zero on any decode error.
    function bit unstuff();
      int         i;
      int         run;
      logic [7:0] code;
      decoded.delete();
      i = 0;
      while (i < stored.size()) begin
        code = stored[i];
        i++;
        run = code - 1;
        if (run > stored.size() - i) return 1'b0;
        for (int k = 0; k < run; k++) begin
          if (decoded.size() >= FRAME_BYTES) return 1'b0;
          decoded.push_back(stored[i + k]);
        end
        i += run;
        if (code != CODE_FULL && i < stored.size()) begin
          if (decoded.size() >= FRAME_BYTES) return 1'b0;
          decoded.push_back(8'h00);
        end
      end
      return 1'b1;
    endfunction

    function void push_beat(logic kind, logic [1:0] chan, logic [7:0] data,
                            logic [1:0] status, logic [5:0] plen, logic last);
      beat_t b;
      b.kind     = kind;
      b.chan     = chan;
      b.data     = data;
      b.status   = status;
      b.plen     = plen;
      b.last     = last;
      b.ok_cnt   = ok_total;
      b.crc_cnt  = crc_bad_total;
      b.dec_cnt  = decode_bad_total;
      b.drop_cnt = dropped_total;
      due_beats.push_back(b);
    endfunction

    // Called for every accepted input beat.
    function void take_rx_byte(logic [7:0] rx);
      int          dlen;
      int          len;
      logic [1:0]  chan;
      logic [15:0] crc_rx;
      if (rx != DELIM) begin
        if (stored.size() >= FRAME_BYTES) dropped_total++;
        else stored.push_back(rx);
        return;
      end
      // A delimiter with nothing stored is ignored.
      if (stored.size() == 0) return;
      dlen = unstuff() ? decoded.size() : 0;
      stored.delete();
      if (dlen < MIN_FRAME || decoded[0] >= NUM_CHANNELS) begin
        decode_bad_total++;
        push_beat(KIND_STATUS, CHAN_NONE, 8'h00, STAT_DEC_FAIL, 6'd0, 1'b1);
        return;
      end
      chan = decoded[0][1:0];
      len  = {decoded[2], decoded[1]};
      if (dlen != len + MIN_FRAME) begin
        decode_bad_total++;
        push_beat(KIND_STATUS, CHAN_NONE, 8'h00, STAT_DEC_FAIL, 6'd0, 1'b1);
        return;
      end
      crc_rx = {decoded[4 + len], decoded[3 + len]};
      if (crc16_of(decoded, 3 + len) != crc_rx) begin
        crc_bad_total++;
        push_beat(KIND_STATUS, CHAN_NONE, 8'h00, STAT_CRC_FAIL, 6'd0, 1'b1);
        return;
      end
      // Good frame: payload only when its channel is enabled, status always.
      ok_total++;
      if (enable_mask[chan]) begin
        for (int k = 0; k < len; k++) begin
          push_beat(KIND_PAYLOAD, chan, decoded[3 + k], STAT_OK, len[5:0], 1'b0);
        end
      end
      push_beat(KIND_STATUS, chan, 8'h00, STAT_OK, len[5:0], 1'b1);
    endfunction

    // Called for every accepted result beat.
    function void check_out_beat(beat_t got);
      beat_t       want;
      logic [31:0] w;
      logic [31:0] g;
      string       name;
      if (due_beats.size() == 0) begin
        flag($sformatf("unexpected result beat, kind %0d channel %0d status %0d",
                       got.kind, got.chan, got.status));
        return;
      end
      want = due_beats.pop_front();
      for (int f = 0; f < 10; f++) begin
        case (f)
          0: begin name = "item_kind";         w = want.kind;     g = got.kind;     end
          1: begin name = "channel";           w = want.chan;     g = got.chan;     end
          2: begin name = "data_byte";         w = want.data;     g = got.data;     end
          3: begin name = "frame_status";      w = want.status;   g = got.status;   end
          4: begin name = "payload_length";    w = want.plen;     g = got.plen;     end
          5: begin name = "last";              w = want.last;     g = got.last;     end
          6: begin name = "ok_count";          w = want.ok_cnt;   g = got.ok_cnt;   end
          7: begin name = "crc_fail_count";    w = want.crc_cnt;  g = got.crc_cnt;  end
          8: begin name = "decode_fail_count"; w = want.dec_cnt;  g = got.dec_cnt;  end
          default: begin
            name = "oversize_count"; w = want.drop_cnt; g = got.drop_cnt;
          end
        endcase
        if (w !== g) flag($sformatf("%s expected 0x%0h, got 0x%0h", name, w, g));
      end
    endfunction

    function void check_drained();
      if (due_beats.size() != 0)
        flag($sformatf("%0d result beats never arrived", due_beats.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic m_tlast;

  deframe_ledger ledger;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit hold_off_req = 1'b0;
  int bytes_sent = 0;

  cobs_crc_datagram_deframer_core #(
    .BUFFER_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watch both sides; every accepted beat goes to the ledger.
  always @(posedge clk) begin
    beat_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) ledger.take_rx_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        got.kind     = m_tuser[0];
        got.chan     = m_tdata[1:0];
        got.data     = m_tdata[9:2];
        got.status   = m_tdata[11:10];
        got.plen     = m_tdata[17:12];
        got.last     = m_tlast;
        got.ok_cnt   = m_tdata[49:18];
        got.crc_cnt  = m_tdata[81:50];
        got.dec_cnt  = m_tdata[113:82];
        got.drop_cnt = m_tdata[145:114];
        ledger.check_out_beat(got);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      m_tready <= rx_gaps ? ($urandom_range(99) >= 25) : 1'b1;
    end
  end

  // End the run when neither side has moved a beat for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one byte and return at the edge where it is taken. Valid stays high.
  task automatic send_byte(input logic [7:0] rx);
    while (tx_gaps && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rx;
    bytes_sent++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Lower valid, wait for every due beat, then let the block go quiet.
  task automatic settle(input int cycles);
    s_tvalid <= 1'b0;
    // Wait so the last delimiter has reached the ledger before the queue is checked.
    @(posedge clk);
    while (ledger.due_beats.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_mask(input logic [2:0] mask);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ledger.enable_mask = mask;
  endtask

  // Build one datagram with the given flaw, stuff it and send it with its delimiter.
  task automatic send_frame(input frame_flaw_t flaw, input logic [7:0] chan, input int plen);
    logic [7:0]  raw[$];
    logic [7:0]  enc[$];
    logic [15:0] len_field;
    logic [15:0] crc;
    int          code_at;
    int          extra;
    int          pick;
    if (flaw == FLAW_NOISE) begin
      // Random nonzero bytes; now and then more than the store can hold.
      extra = ($urandom_range(9) == 0) ? $urandom_range(70, 66) : $urandom_range(12, 1);
      repeat (extra) enc.push_back(8'($urandom_range(255, 1)));
    end else begin
      if (flaw == FLAW_SHORT) begin
        repeat ($urandom_range(4, 1)) raw.push_back(8'($urandom));
      end else begin
        len_field = 16'(plen);
        if (flaw == FLAW_LEN) len_field = len_field ^ 16'($urandom_range(65535, 1));
        raw.push_back(chan);
        raw.push_back(len_field[7:0]);
        raw.push_back(len_field[15:8]);
        // Payload leans toward zeros and all-ones to stress the stuffing.
        repeat (plen) begin
          pick = $urandom_range(9);
          raw.push_back(pick < 2 ? 8'h00 : (pick == 2 ? 8'hFF : 8'($urandom)));
        end
        crc = deframe_ledger::crc16_of(raw, raw.size());
        if (flaw == FLAW_CRC) crc = crc ^ 16'(1 << $urandom_range(15));
        raw.push_back(crc[7:0]);
        raw.push_back(crc[15:8]);
      end
      // Byte stuffing. Frames stay under 254 bytes, so no block ever fills up.
      code_at = 0;
      enc.push_back(8'h01);
      foreach (raw[i]) begin
        if (raw[i] == 8'h00) begin
          code_at = enc.size();
          enc.push_back(8'h01);
        end else begin
          enc.push_back(raw[i]);
          enc[code_at] = enc[code_at] + 8'd1;
        end
      end
      // A full-size frame followed by bytes that do not fit.
      if (flaw == FLAW_OVERSIZE)
        repeat ($urandom_range(4, 1)) enc.push_back(8'($urandom_range(255, 1)));
    end
    // Now and then a stray delimiter that the block must ignore.
    if ($urandom_range(9) == 0) send_byte(DELIM);
    foreach (enc[i]) send_byte(enc[i]);
    send_byte(DELIM);
  endtask

  // Random frames until roughly the given number of bytes has gone in.
  task automatic run_frames(input int byte_budget);
    frame_flaw_t flaw;
    int          r;
    int          start;
    int          plen;
    logic [7:0]  chan;
    start = bytes_sent;
    while (bytes_sent - start < byte_budget) begin
      r = $urandom_range(99);
      flaw = (r < 55) ? FLAW_NONE : (r < 65) ? FLAW_CRC : (r < 72) ? FLAW_CHAN :
             (r < 79) ? FLAW_LEN : (r < 86) ? FLAW_SHORT : (r < 95) ? FLAW_NOISE :
             FLAW_OVERSIZE;
      chan = (flaw == FLAW_CHAN) ? 8'($urandom_range(255, 3)) : 8'($urandom_range(2));
      // Mostly short payloads, a few near the largest that fits.
      if (flaw == FLAW_OVERSIZE) plen = 58;
      else if ($urandom_range(19) == 0) plen = $urandom_range(58, 30);
      else plen = $urandom_range(8);
      send_frame(flaw, chan, plen);
    end
  endtask

  // Main sequence.
  initial begin
    ledger = new;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_mask(3'b111);

    // Directed frames: ignored delimiter, empty header fields, short and broken frames.
    send_byte(DELIM);
    send_frame(FLAW_NONE, 8'd0, 0);
    send_frame(FLAW_NONE, 8'd2, 1);
    send_byte(8'h01);
    send_byte(DELIM);
    send_byte(8'h05);
    send_byte(8'h11);
    send_byte(DELIM);
    send_frame(FLAW_CHAN, 8'hFF, 0);
    send_frame(FLAW_CRC, 8'd1, 0);
    settle(SETTLE_CYCLES);

    // Long result-side hold-off while frames keep coming.
    hold_off_req = 1'b1;
    run_frames(40);
    settle(SETTLE_CYCLES);

    // Every channel disabled: good frames report status only.
    write_mask(3'b000);
    run_frames(25);
    settle(SETTLE_CYCLES);

    // A stretch without any idling on either side.
    write_mask(3'b101);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_frames(25);
    settle(SETTLE_CYCLES);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    write_mask(3'b010);
    run_frames(25);
    settle(SETTLE_CYCLES);

    write_mask(3'($urandom_range(7)));
    run_frames(25);
    settle(SETTLE_CYCLES);

    write_mask(3'b111);
    run_frames(20);
    settle(TAIL_CYCLES);

    ledger.check_drained();
    if (ledger.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
